// File: sv/ttip_pkg.sv
`timescale 1ns / 1ps

package ttip_pkg;

   localparam int CHAR_W   = 8;
   localparam int RADIX_W  = 6;
   localparam int VALUE_W  = 64;
   localparam int OFFSET_W = 12;
   localparam int DIGIT_W  = 6;

   // configuration register indexes
   localparam logic CSR_NUMBER_BASE = 1'b0;
   localparam logic CSR_WIDE_MODE   = 1'b1;

   localparam logic [RADIX_W-1:0] BASE_DETECT  = 6'd0;
   localparam logic [RADIX_W-1:0] BASE_MIN     = 6'd2;
   localparam logic [RADIX_W-1:0] BASE_OCTAL   = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_DECIMAL = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX     = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_MAX     = 6'd36;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 6'd10;

   typedef struct packed {
      logic               digit_ok;
      logic [VALUE_W-1:0] acc_next;
   } mac_result_type;

endpackage

// File: sv/text_to_integer_parser.sv
`timescale 1ns / 1ps

// Streaming string-to-unsigned converter with strtoul behavior.
// Input channel (req_*): one character word per handshake; a NUL word ends the
// string. Leading whitespace is skipped, an optional sign is taken, and the
// radix comes from csr register number_base (0 detects it from the prefix).
// Result channel (rsp_*): one word per string, carrying the value, the offset
// where parsing stopped and a flag telling whether any digit was seen.
// Config port (csr_*): single-cycle writes, index 0 number_base, index 1
// wide_mode (0 wraps the value at 32 bits, 1 at 64 bits). Write only while idle.
// Throughput: one character per cycle when not stalled. Each character passes
// through one 64 x 6 multiply-add and a phase update straight into the state
// registers. Latency: the result word is valid the cycle after the NUL is accepted.
// Stall: the result register holds while rsp_ready is low; a new character is
// taken in the same cycle the pending result leaves, otherwise req_ready drops.
// Reset: synchronous, clears the parser state and the result valid flag and
// loads number_base = 10, wide_mode = 1.

module text_to_integer_parser
   import ttip_pkg::*;
#(
   parameter int MAX_LEN = 4096
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CHAR_W-1:0]   req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_parsed_value,
   output logic [OFFSET_W-1:0] rsp_end_offset,
   output logic                rsp_digits_found,
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [RADIX_W-1:0]  csr_wdata
);

   // positions saturate here; the offset field is 12 bits wide
   localparam int POS_MAX = ((MAX_LEN - 1) < 4095) ? (MAX_LEN - 1) : 4095;
   localparam int POS_W   = $clog2(POS_MAX + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_MAX);

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_HEXPFX,
      PH_DIGITS,
      PH_DONE,
      PH_INVALID
   } phase_type;

   // configuration
   logic [RADIX_W-1:0] number_base_ff, number_base_in;
   logic               wide_mode_ff, wide_mode_in;

   // per-string parser state
   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               minus_ff, minus_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [POS_W-1:0]   stop_ff, stop_in;
   logic               any_ff, any_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [OFFSET_W-1:0] rsp_end_ff, rsp_end_in;
   logic                rsp_found_ff, rsp_found_in;

   logic               req_fire;
   logic               end_of_string;
   logic               is_space;
   logic               base_ok;
   logic               do_take;
   logic [RADIX_W-1:0] take_radix;
   logic [POS_W-1:0]   pos_next;
   logic [VALUE_W-1:0] final_value;
   logic [POS_W-1:0]   final_end;
   logic               final_found;
   mac_result_type     mac;

   // a character may enter whenever the result slot is free or draining
   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign req_fire      = req_valid && req_ready;
   assign end_of_string = (req_char_code == CHAR_NUL);

   assign is_space = (req_char_code == CHAR_SPACE)
                  || ((req_char_code >= CHAR_TAB) && (req_char_code <= CHAR_CR));
   assign base_ok  = (number_base_ff == BASE_DETECT)
                  || ((number_base_ff >= BASE_MIN) && (number_base_ff <= BASE_MAX));
   assign pos_next = (pos_ff == POS_LIMIT) ? pos_ff : pos_ff + 1'b1;

   // radix used if this character goes to the digit accumulator
   always_comb begin
      case (phase_ff)
         PH_SPACE:  take_radix = (number_base_ff == BASE_DETECT) ? BASE_DECIMAL
                                                                 : number_base_ff;
         PH_SIGNED: take_radix = (radix_ff == BASE_DETECT) ? BASE_DECIMAL : radix_ff;
         PH_ZERO:   take_radix = (radix_ff == BASE_DETECT) ? BASE_OCTAL : radix_ff;
         default:   take_radix = radix_ff;
      endcase
   end

   ttip_digit_mac u_digit_mac (
      .char_code (req_char_code),
      .radix     (take_radix),
      .acc       (acc_ff),
      .result    (mac)
   );

   // value and stop offset reported when the NUL arrives
   always_comb begin
      final_value = '0;
      final_end   = start_ff;
      final_found = 1'b0;
      case (phase_ff)
         PH_SPACE: begin
            final_end = base_ok ? pos_ff : '0;
         end
         PH_INVALID: begin
            final_end = '0;
         end
         PH_ZERO: begin
            // a lone zero is a valid number
            final_found = 1'b1;
            final_end   = pos_ff;
         end
         PH_DIGITS, PH_DONE: begin
            if (any_ff) begin
               final_found = 1'b1;
               final_end   = stop_ff;
               final_value = minus_ff ? (VALUE_W'(0) - acc_ff) : acc_ff;
            end
         end
         default: begin
            // sign or bare hex prefix only: no digits, stop after whitespace
         end
      endcase
      if (!wide_mode_ff) begin
         final_value = {{(VALUE_W/2){1'b0}}, final_value[VALUE_W/2-1:0]};
      end
   end

   always_comb begin
      number_base_in = number_base_ff;
      wide_mode_in   = wide_mode_ff;
      phase_in       = phase_ff;
      acc_in         = acc_ff;
      minus_in       = minus_ff;
      radix_in       = radix_ff;
      pos_in         = pos_ff;
      start_in       = start_ff;
      stop_in        = stop_ff;
      any_in         = any_ff;
      do_take        = 1'b0;

      // drain the result, then possibly load a new one
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_found_in = rsp_found_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_NUMBER_BASE: number_base_in = csr_wdata;
            CSR_WIDE_MODE:   wide_mode_in   = csr_wdata[0];
            default:         ;
         endcase
      end

      if (req_fire && end_of_string) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = final_value;
         rsp_end_in   = OFFSET_W'(final_end);
         rsp_found_in = final_found;
         // clear for the next string
         phase_in = PH_SPACE;
         acc_in   = '0;
         minus_in = 1'b0;
         radix_in = '0;
         pos_in   = '0;
         start_in = '0;
         stop_in  = '0;
         any_in   = 1'b0;
      end else if (req_fire) begin
         case (phase_ff)
            PH_SPACE: begin
               if (!is_space) begin
                  start_in = pos_ff;
                  if (!base_ok) begin
                     phase_in = PH_INVALID;
                  end else begin
                     radix_in = number_base_ff;
                     if ((req_char_code == CHAR_PLUS) || (req_char_code == CHAR_MINUS)) begin
                        minus_in = (req_char_code == CHAR_MINUS);
                        phase_in = PH_SIGNED;
                     end else if ((req_char_code == CHAR_ZERO)
                                  && ((number_base_ff == BASE_DETECT)
                                      || (number_base_ff == BASE_HEX))) begin
                        phase_in = PH_ZERO;
                     end else begin
                        do_take = 1'b1;
                     end
                  end
               end
            end
            PH_SIGNED: begin
               if ((req_char_code == CHAR_ZERO)
                   && ((radix_ff == BASE_DETECT) || (radix_ff == BASE_HEX))) begin
                  phase_in = PH_ZERO;
               end else begin
                  do_take = 1'b1;
               end
            end
            PH_ZERO: begin
               if ((req_char_code == CHAR_LOWER_X) || (req_char_code == CHAR_UPPER_X)) begin
                  radix_in = BASE_HEX;
                  phase_in = PH_HEXPFX;
               end else begin
                  // the leading zero already counts as a digit
                  any_in   = 1'b1;
                  stop_in  = pos_ff;
                  do_take  = 1'b1;
               end
            end
            PH_HEXPFX, PH_DIGITS: begin
               do_take = 1'b1;
            end
            default: begin
               // done or invalid: drop characters until the NUL
            end
         endcase

         if (do_take) begin
            radix_in = take_radix;
            if (mac.digit_ok) begin
               acc_in   = mac.acc_next;
               any_in   = 1'b1;
               stop_in  = pos_next;
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE;
            end
         end
         pos_in = pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_DECIMAL;
         wide_mode_ff   <= 1'b1;
         phase_ff       <= PH_SPACE;
         acc_ff         <= '0;
         minus_ff       <= 1'b0;
         radix_ff       <= '0;
         pos_ff         <= '0;
         start_ff       <= '0;
         stop_ff        <= '0;
         any_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         number_base_ff <= number_base_in;
         wide_mode_ff   <= wide_mode_in;
         phase_ff       <= phase_in;
         acc_ff         <= acc_in;
         minus_ff       <= minus_in;
         radix_ff       <= radix_in;
         pos_ff         <= pos_in;
         start_ff       <= start_in;
         stop_ff        <= stop_in;
         any_ff         <= any_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = rsp_value_ff;
   assign rsp_end_offset   = rsp_end_ff;
   assign rsp_digits_found = rsp_found_ff;

`ifndef SYNTHESIS
   // a string without digits always reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_value_ff == '0)
      else $error("nonzero value without digits");

   // accumulated digits only exist in the digit or done phases
   assert property (@(posedge clock) disable iff (reset)
      any_ff |-> (phase_ff == PH_DIGITS) || (phase_ff == PH_DONE))
      else $error("digit flag set outside digit phases");

   // narrow mode clears the upper half of the result
   assert property (@(posedge clock) disable iff (reset)
      req_fire && end_of_string && !wide_mode_ff |=> rsp_value_ff[VALUE_W-1:VALUE_W/2] == '0)
      else $error("narrow result has upper bits set");

   // no result is overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_fire)
      else $error("character accepted over a stalled result");
`endif

endmodule

// File: sv/ttip_digit_mac.sv
`timescale 1ns / 1ps

module ttip_digit_mac
   import ttip_pkg::*;
(
   input  logic [CHAR_W-1:0]  char_code,
   input  logic [RADIX_W-1:0] radix,
   input  logic [VALUE_W-1:0] acc,
   output mac_result_type     result
);

   logic               is_num;
   logic               is_lower;
   logic               is_upper;
   logic [CHAR_W-1:0]  raw;
   logic [DIGIT_W-1:0] dval;
   logic [VALUE_W-1:0] prod;

   // decode one character into its digit value
   always_comb begin
      is_num   = (char_code >= CHAR_ZERO)    && (char_code <= CHAR_NINE);
      is_lower = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_Z);
      is_upper = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z);
      if (is_num) begin
         raw = char_code - CHAR_ZERO;
      end else if (is_lower) begin
         raw = char_code - CHAR_LOWER_A + CHAR_W'(LETTER_OFFSET);
      end else begin
         raw = char_code - CHAR_UPPER_A + CHAR_W'(LETTER_OFFSET);
      end
      dval = raw[DIGIT_W-1:0];
   end

   // 64 x 6 multiply-add, wraps at 64 bits
   assign prod            = acc * VALUE_W'(radix);
   assign result.digit_ok = (is_num || is_lower || is_upper) && (dval < radix);
   assign result.acc_next = prod + VALUE_W'(dval);

endmodule

// File: sim/text_to_integer_parser_test.sv
`timescale 1ns / 1ps

module text_to_integer_parser_test;
   import ttip_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 7;
   localparam int MAX_LEN         = 4096;
   localparam int POS_LIMIT       = (MAX_LEN - 1 < 4095) ? MAX_LEN - 1 : 4095;
   localparam int SETTLE_CYCLES   = 4;      // result shows up in the cycle after the NUL
   localparam int IDLE_PERCENT    = 12;
   localparam int LONG_HOLD       = 300;
   localparam int CHARS_PER_PHASE = 30;
   localparam int RANDOM_PHASES   = 8;
   localparam int FINAL_WAIT      = 2000;
   localparam int RUN_LIMIT_NS    = 5_000_000;

   // where the parser is within the current string
   typedef enum logic [2:0] {
      SCAN_SPACE,
      SCAN_SIGN,
      SCAN_ZERO,
      SCAN_PREFIX,
      SCAN_DIGITS,
      SCAN_DONE,
      SCAN_BAD
   } scan_phase_type;

   typedef struct {
      logic [VALUE_W-1:0]  value;
      logic [OFFSET_W-1:0] offset;
      logic                found;
   } parse_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_char_code = CHAR_NUL;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_parsed_value;
   logic [OFFSET_W-1:0] rsp_end_offset;
   logic                rsp_digits_found;
   logic                csr_wr_en = 1'b0;
   logic                csr_index = CSR_NUMBER_BASE;
   logic [RADIX_W-1:0]  csr_wdata = '0;

   text_to_integer_parser #(.MAX_LEN(MAX_LEN)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_digits_found (rsp_digits_found),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // character words waiting to be offered, and parse results not yet returned
   logic [CHAR_W-1:0] char_backlog[$];
   parse_result_type  pending_results[$];

   // register copies, written only while the block is idle
   logic [RADIX_W-1:0] cfg_base = BASE_DECIMAL;
   logic               cfg_wide = 1'b1;

   // parser state mirror
   scan_phase_type      phase_q = SCAN_SPACE;
   logic [VALUE_W-1:0]  acc_q   = '0;
   logic                neg_q   = 1'b0;
   logic [RADIX_W-1:0]  radix_q = '0;
   logic [OFFSET_W-1:0] pos_q   = '0;
   logic [OFFSET_W-1:0] start_q = '0;
   logic [OFFSET_W-1:0] stop_q  = '0;
   logic                seen_q  = 1'b0;

   int mismatches     = 0;
   int chars_sent     = 0;
   int results_seen   = 0;
   int config_writes  = 0;
   bit calm_tail      = 1'b0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int tx_gap         = 0;
   int rx_hold        = 0;

   task automatic log_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Parser mirror
   // ---------------------------------------------------------------------

   function automatic bit is_blank(input logic [CHAR_W-1:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   // digit weight of a character, -1 when it is no alphanumeric
   function automatic int digit_value(input logic [CHAR_W-1:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c - CHAR_LOWER_A) + 10;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c - CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   function automatic bit base_valid(input logic [RADIX_W-1:0] b);
      return b == BASE_DETECT || (b >= BASE_MIN && b <= BASE_MAX);
   endfunction

   // advance a position, holding at the top
   function automatic logic [OFFSET_W-1:0] bump(input logic [OFFSET_W-1:0] p);
      return (int'(p) < POS_LIMIT) ? p + 1'b1 : OFFSET_W'(POS_LIMIT);
   endfunction

   task automatic take_digit(input logic [CHAR_W-1:0] c);
      int d;
      d = digit_value(c);
      if (d >= 0 && d < int'(radix_q)) begin
         acc_q   = acc_q * VALUE_W'(radix_q) + VALUE_W'(d);
         seen_q  = 1'b1;
         stop_q  = bump(pos_q);
         phase_q = SCAN_DIGITS;
      end else begin
         phase_q = SCAN_DONE;
      end
   endtask

   // first character after whitespace and sign
   task automatic first_char(input logic [CHAR_W-1:0] c);
      if (c == CHAR_ZERO && (radix_q == BASE_DETECT || radix_q == BASE_HEX)) begin
         phase_q = SCAN_ZERO;
      end else begin
         if (radix_q == BASE_DETECT) radix_q = BASE_DECIMAL;
         take_digit(c);
      end
   endtask

   // advance the mirror by one accepted word; a NUL yields the expected result
   task automatic parse_char(input logic [CHAR_W-1:0] c);
      parse_result_type res;
      if (c == CHAR_NUL) begin
         res.value  = '0;
         res.offset = start_q;
         res.found  = 1'b0;
         case (phase_q)
            SCAN_SPACE: res.offset = base_valid(cfg_base) ? pos_q : '0;
            SCAN_BAD: res.offset = '0;
            SCAN_ZERO: begin
               res.found  = 1'b1;
               res.offset = pos_q;
            end
            SCAN_DIGITS, SCAN_DONE: begin
               if (seen_q) begin
                  res.found  = 1'b1;
                  res.offset = stop_q;
                  res.value  = neg_q ? VALUE_W'(0) - acc_q : acc_q;
               end
            end
            default: ;
         endcase
         if (!cfg_wide) res.value[VALUE_W-1:32] = '0;
         pending_results.push_back(res);
         phase_q = SCAN_SPACE;
         acc_q   = '0;
         neg_q   = 1'b0;
         radix_q = '0;
         pos_q   = '0;
         start_q = '0;
         stop_q  = '0;
         seen_q  = 1'b0;
      end else begin
         case (phase_q)
            SCAN_SPACE: begin
               if (!is_blank(c)) begin
                  start_q = pos_q;
                  if (!base_valid(cfg_base)) begin
                     phase_q = SCAN_BAD;
                  end else begin
                     radix_q = cfg_base;
                     if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        neg_q   = (c == CHAR_MINUS);
                        phase_q = SCAN_SIGN;
                     end else begin
                        first_char(c);
                     end
                  end
               end
            end
            SCAN_SIGN: first_char(c);
            SCAN_ZERO: begin
               if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
                  radix_q = BASE_HEX;
                  phase_q = SCAN_PREFIX;
               end else begin
                  // the zero alone already counts as a digit
                  if (radix_q == BASE_DETECT) radix_q = BASE_OCTAL;
                  acc_q  = '0;
                  seen_q = 1'b1;
                  stop_q = pos_q;
                  take_digit(c);
               end
            end
            SCAN_PREFIX, SCAN_DIGITS: take_digit(c);
            default: ;
         endcase
         pos_q = bump(pos_q);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender: offer backlog words, idle in random bursts, track accepted words
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : sender
      logic              nv;
      logic [CHAR_W-1:0] nc;
      int                ng;
      nv = req_valid;
      nc = req_char_code;
      ng = tx_gap;
      if (!reset) begin
         if (req_valid && req_ready) begin
            parse_char(req_char_code);
            chars_sent++;
            nv = 1'b0;
         end
         // hold the current word until it is taken; otherwise pick the next
         if (!nv) begin
            if (ng > 0) begin
               ng--;
            end else if (!calm_tail && $urandom_range(0, 99) < IDLE_PERCENT) begin
               ng = $urandom_range(0, 9);
            end else if (char_backlog.size() > 0) begin
               nc = char_backlog.pop_front();
               nv = 1'b1;
            end
         end
      end
      req_valid     <= nv;
      req_char_code <= nc;
      tx_gap        <= ng;
   end

   // ---------------------------------------------------------------------
   // Receiver: stall at random, serve long hold-off requests, check results
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : receiver
      parse_result_type want;
      int               nh;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            log_mismatch($sformatf("unexpected result word: value %0h offset %0d digits %0b",
                                   rsp_parsed_value, rsp_end_offset, rsp_digits_found));
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            if (rsp_parsed_value !== want.value)
               log_mismatch($sformatf("result %0d parsed_value %0h, expected %0h",
                                      results_seen, rsp_parsed_value, want.value));
            if (rsp_end_offset !== want.offset)
               log_mismatch($sformatf("result %0d end_offset %0d, expected %0d",
                                      results_seen, rsp_end_offset, want.offset));
            if (rsp_digits_found !== want.found)
               log_mismatch($sformatf("result %0d digits_found %0b, expected %0b",
                                      results_seen, rsp_digits_found, want.found));
         end
      end
      nh = rx_hold;
      if (hold_requests != hold_served) begin
         // long hold-off: let the block back up and stall its input
         hold_served <= hold_requests;
         nh = LONG_HOLD;
      end else if (nh > 0) begin
         nh--;
      end else if (!calm_tail && $urandom_range(0, 99) < IDLE_PERCENT) begin
         nh = $urandom_range(1, 10);
      end
      rx_hold   <= nh;
      rsp_ready <= (nh == 0);
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   task automatic add_chars(input string s);
      for (int i = 0; i < s.len(); i++) char_backlog.push_back(CHAR_W'(s[i]));
   endtask

   task automatic add_string(input string s);
      add_chars(s);
      char_backlog.push_back(CHAR_NUL);
   endtask

   function automatic logic [CHAR_W-1:0] blank_char();
      int k;
      k = $urandom_range(0, 5);
      return (k == 5) ? CHAR_SPACE : CHAR_TAB + CHAR_W'(k);
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input int d);
      if (d < 10) return CHAR_ZERO + CHAR_W'(d);
      return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + CHAR_W'(d - 10);
   endfunction

   // one string, mostly well formed for the current base; returns its length
   function automatic int add_random_string();
      int                 n;
      int                 before_len;
      logic [RADIX_W-1:0] r;
      before_len = char_backlog.size();
      if ($urandom_range(0, 99) < 15) begin
         // noise: arbitrary nonzero bytes
         n = $urandom_range(0, 6);
         repeat (n) char_backlog.push_back(CHAR_W'($urandom_range(1, 255)));
      end else begin
         repeat ($urandom_range(0, 3)) char_backlog.push_back(blank_char());
         case ($urandom_range(0, 2))
            1: char_backlog.push_back(CHAR_PLUS);
            2: char_backlog.push_back(CHAR_MINUS);
            default: ;
         endcase
         r = cfg_base;
         if ((cfg_base == BASE_DETECT || cfg_base == BASE_HEX) && $urandom_range(0, 2) == 0) begin
            char_backlog.push_back(CHAR_ZERO);
            char_backlog.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
            r = BASE_HEX;
         end else if (cfg_base == BASE_DETECT && $urandom_range(0, 2) == 0) begin
            char_backlog.push_back(CHAR_ZERO);
            r = BASE_OCTAL;
         end else if (cfg_base == BASE_DETECT) begin
            r = BASE_DECIMAL;
         end
         if (r < BASE_MIN || r > BASE_MAX) r = BASE_MAX;
         // long runs push the value past 32 and 64 bits in all but the smallest bases
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
         repeat (n) char_backlog.push_back(digit_char($urandom_range(0, int'(r) - 1)));
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
               char_backlog.push_back(CHAR_W'($urandom_range(1, 255)));
      end
      char_backlog.push_back(CHAR_NUL);
      return char_backlog.size() - before_len;
   endfunction

   task automatic fill_random(input int budget);
      int added;
      added = 0;
      while (added < budget) added += add_random_string();
   endtask

   // wait until nothing is offered or expected, then let the block settle
   task automatic wait_idle();
      while (char_backlog.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers at consecutive edges; call only while idle
   task automatic set_config(input logic [RADIX_W-1:0] base, input logic wide);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_NUMBER_BASE;
      csr_wdata <= base;
      cfg_base   = base;
      @(posedge clock);
      csr_index <= CSR_WIDE_MODE;
      csr_wdata <= RADIX_W'(wide);
      cfg_wide   = wide;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      config_writes += 2;
   endtask

   initial begin : stimulus
      logic [RADIX_W-1:0] base;
      logic               wide;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, decimal and 64-bit wrap
      add_string("-42");
      add_string("+7x");
      add_string("");
      add_string("   ");
      add_string("-");
      add_string("18446744073709551617");
      char_backlog.push_back(8'hFF);
      char_backlog.push_back(CHAR_NUL);
      for (logic [CHAR_W-1:0] c = CHAR_TAB; c <= CHAR_CR; c++) char_backlog.push_back(c);
      add_string(" 9");
      wait_idle();

      // directed: base detection, bare and broken prefixes, octal stop
      set_config(BASE_DETECT, 1'b1);
      add_string("0x1F");
      add_string("0");
      add_string("017");
      add_string("0x");
      add_string("0xg");
      add_string("-0X7fffffffffffffff");
      add_string("09");
      wait_idle();

      // directed: hex with optional prefix, 32-bit wrap
      set_config(BASE_HEX, 1'b0);
      add_string("0xFFFFFFFFF");
      add_string("-1");
      add_string("0x");
      add_string("Zz");
      wait_idle();

      set_config(BASE_MAX, 1'b0);
      add_string("zZ09");
      add_string("-zzzzzzzzzz");
      wait_idle();

      set_config(BASE_MIN, 1'b1);
      add_string("1012");
      add_string("-11");
      wait_idle();

      set_config(BASE_OCTAL, 1'b1);
      add_string("0x12");
      wait_idle();

      // directed: invalid bases give zero at offset zero
      set_config(RADIX_W'(1), 1'b1);
      add_string("  123");
      add_string("");
      wait_idle();
      set_config(RADIX_W'(63), 1'b0);
      add_string("\t-5");
      add_string(" ");
      wait_idle();

      // random phases over several settings
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin base = BASE_DETECT;  wide = 1'b1; end
            1: begin base = BASE_DECIMAL; wide = 1'b0; end
            2: begin base = BASE_HEX;     wide = 1'b1; end
            3: begin base = BASE_OCTAL;   wide = 1'b0; end
            4: begin base = BASE_MIN;     wide = 1'b1; end
            5: begin base = BASE_MAX;     wide = 1'b0; end
            6: begin
               base = RADIX_W'($urandom_range(int'(BASE_MIN), int'(BASE_MAX)));
               wide = 1'(($urandom_range(0, 1)));
            end
            default: begin base = BASE_DETECT; wide = 1'b0; end
         endcase
         set_config(base, wide);
         if (ph == RANDOM_PHASES - 1) calm_tail = 1'b1;
         if (ph == 2) hold_requests++;
         if (ph == 4) begin
            // pause the sender until every result of the first half is back
            fill_random(CHARS_PER_PHASE / 2);
            wait_idle();
            fill_random(CHARS_PER_PHASE / 2);
         end else begin
            fill_random(CHARS_PER_PHASE);
         end
         if (ph != RANDOM_PHASES - 1) wait_idle();
      end

      // drain: wait for the last words to go out, then for the results
      while (char_backlog.size() != 0 || req_valid) @(posedge clock);
      for (int i = 0; i < FINAL_WAIT && pending_results.size() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_results.size() != 0) begin
         log_mismatch($sformatf("expected result never arrived: value %0h offset %0d",
                                pending_results[0].value, pending_results[0].offset));
         void'(pending_results.pop_front());
      end

      $display("Run covered %0d character words and %0d result words over %0d register writes,",
               chars_sent, results_seen, config_writes);
      $display("including detected, invalid and extreme bases, both widths and long stalls.");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d results still expected", pending_results.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: text_to_integer_parser.f
sv/ttip_pkg.sv
sv/ttip_digit_mac.sv
sv/text_to_integer_parser.sv
sim/text_to_integer_parser_test.sv
